>>> design/serial_packet_deframer_unit_assert.svh
// assertion macros for the packet deframer
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SERIAL_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define SERIAL_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define SPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/spd_pkg.sv
// shared types and constants of the packet deframer
// no dependencies
package spd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hCC;
  localparam logic [7:0] SYNC_SECOND = 8'h57;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_C = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_TAG   = 3'd2,
    PH_LEN   = 3'd3,
    PH_CMD   = 3'd4,
    PH_DATA  = 3'd5,
    PH_CSUM  = 3'd6
  } spd_phase_e;

  typedef enum logic [1:0] {
    KIND_LEN  = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_CSUM = 2'd3
  } spd_kind_e;

endpackage

>>> design/spd_if.sv
// word channels of the packet deframer: received bytes in, packet bytes out
// depends on nothing
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       end_of_packet;
  logic       checksum_ok;
  logic       sequence_ok;
  logic       to_response;
  logic [7:0] packet_tag;

  modport source (output valid, output out_byte, output byte_kind, output end_of_packet,
                  output checksum_ok, output sequence_ok, output to_response,
                  output packet_tag, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input end_of_packet,
                  input checksum_ok, input sequence_ok, input to_response,
                  input packet_tag, output ready);
endinterface

>>> design/serial_packet_deframer_unit.sv
// a result word reaches the output register in the cycle after its byte is accepted
// one byte per cycle while not stalled; the per-byte phase update is the only loop
// input is taken whenever the output register is empty or being drained
// reset (asynchronous, active low): hunt for the first sync byte, sums and tags
// cleared, first sequence mismatch excused, route registers zero
// depends on spd_pkg, spd_if and serial_packet_deframer_unit_assert.svh
`include "serial_packet_deframer_unit_assert.svh"

module serial_packet_deframer_unit
  import spd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  spd_in_if.sink               rx_i,
  spd_out_if.source            res_o
);

  logic [7:0] route_a_q, route_b_q, route_c_q;

  spd_phase_e phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] tag_q, tag_d;
  logic [7:0] last_good_q, last_good_d;
  logic       excuse_q, excuse_d;
  logic       route_q, route_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  spd_kind_e  kind_q, kind_d;
  logic       eop_q, eop_d;
  logic       csok_q, csok_d;
  logic       seqok_q, seqok_d;
  logic       resp_q, resp_d;
  logic [7:0] ptag_q, ptag_d;

  logic       in_ready;
  logic       in_acc;
  logic [7:0] b;
  logic [7:0] sum_next;
  logic [7:0] left_dec;
  logic       cmd_match;
  logic       follows;
  logic       csok;

  assign in_ready = !out_valid_q || res_o.ready;
  assign in_acc   = rx_i.valid && in_ready;
  assign b        = rx_i.rx_byte;

  assign sum_next  = sum_q + b;
  assign left_dec  = bytes_left_q - 8'd1;
  assign cmd_match = (b == route_a_q) || (b == route_b_q) || (b == route_c_q);
  assign follows   = ((last_good_q + 8'd1) == tag_q);
  assign csok      = (sum_q == b);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_a_q <= '0;
      route_b_q <= '0;
      route_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROUTE_A: route_a_q <= cfg_data_i;
        CFG_ROUTE_B: route_b_q <= cfg_data_i;
        CFG_ROUTE_C: route_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      unique case (phase_q)
        PH_HUNT2: phase_d = (b == SYNC_SECOND) ? PH_TAG : PH_HUNT1;
        PH_TAG:   phase_d = PH_LEN;
        PH_LEN:   phase_d = PH_CMD;
        PH_CMD:   phase_d = (bytes_left_q == 8'd0) ? PH_CSUM : PH_DATA;
        PH_DATA:  phase_d = (left_dec == 8'd0) ? PH_CSUM : PH_DATA;
        PH_CSUM:  phase_d = PH_HUNT1;
        default:  phase_d = (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      endcase
    end
  end

  // packet state and result word
  always_comb begin
    bytes_left_d = bytes_left_q;
    sum_d        = sum_q;
    tag_d        = tag_q;
    last_good_d  = last_good_q;
    excuse_d     = excuse_q;
    route_d      = route_q;

    out_valid_d = out_valid_q && !res_o.ready;
    out_byte_d  = out_byte_q;
    kind_d      = kind_q;
    eop_d       = eop_q;
    csok_d      = csok_q;
    seqok_d     = seqok_q;
    resp_d      = resp_q;
    ptag_d      = ptag_q;

    if (in_acc) begin
      // defaults for a result word built from this byte
      out_byte_d = b;
      eop_d      = 1'b0;
      csok_d     = 1'b0;
      seqok_d    = 1'b0;
      resp_d     = route_q;
      ptag_d     = tag_q;
      kind_d     = KIND_DATA;
      unique case (phase_q)
        PH_HUNT2: ;
        PH_TAG: begin
          tag_d = b;
        end
        PH_LEN: begin
          bytes_left_d = b;
          sum_d        = b;
          route_d      = 1'b0;
          out_valid_d  = 1'b1;
          kind_d       = KIND_LEN;
          resp_d       = 1'b0;
        end
        PH_CMD: begin
          sum_d       = sum_next;
          route_d     = cmd_match;
          out_valid_d = 1'b1;
          kind_d      = KIND_CMD;
          resp_d      = cmd_match;
        end
        PH_DATA: begin
          sum_d        = sum_next;
          bytes_left_d = left_dec;
          out_valid_d  = 1'b1;
          kind_d       = KIND_DATA;
        end
        PH_CSUM: begin
          out_valid_d  = 1'b1;
          kind_d       = KIND_CSUM;
          eop_d        = 1'b1;
          csok_d       = csok;
          seqok_d      = follows || excuse_q;
          bytes_left_d = '0;
          sum_d        = '0;
          if (csok) begin
            last_good_d = tag_q;
            if (!follows) begin
              excuse_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control and packet state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT1;
      bytes_left_q <= '0;
      sum_q        <= '0;
      tag_q        <= '0;
      last_good_q  <= '0;
      excuse_q     <= 1'b1;
      route_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      sum_q        <= sum_d;
      tag_q        <= tag_d;
      last_good_q  <= last_good_d;
      excuse_q     <= excuse_d;
      route_q      <= route_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    kind_q     <= kind_d;
    eop_q      <= eop_d;
    csok_q     <= csok_d;
    seqok_q    <= seqok_d;
    resp_q     <= resp_d;
    ptag_q     <= ptag_d;
  end

  assign rx_i.ready          = in_ready;
  assign res_o.valid         = out_valid_q;
  assign res_o.out_byte      = out_byte_q;
  assign res_o.byte_kind     = kind_q;
  assign res_o.end_of_packet = eop_q;
  assign res_o.checksum_ok   = csok_q;
  assign res_o.sequence_ok   = seqok_q;
  assign res_o.to_response   = resp_q;
  assign res_o.packet_tag    = ptag_q;

  // checks
  `SPD_ASSERT_NEXT(a_csum_restarts_hunt, in_acc && phase_q == PH_CSUM,
    phase_q == PH_HUNT1 && sum_q == 8'd0 && bytes_left_q == 8'd0 && out_valid_q && eop_q,
    "checksum byte did not end the packet")
  `SPD_ASSERT_NEXT(a_len_gives_word, in_acc && phase_q == PH_LEN,
    out_valid_q && kind_q == KIND_LEN && !resp_q,
    "length byte did not produce a length word")
  `SPD_ASSERT_NEXT(a_excuse_spent_once, !excuse_q, !excuse_q,
    "sequence excuse came back after being used")
  `SPD_ASSERT_NOW(a_verdict_only_at_end, out_valid_q && kind_q != KIND_CSUM,
    !eop_q && !csok_q && !seqok_q,
    "end-of-packet verdict on a non-checksum word")

endmodule

>>> sim/testbench.sv
// self-checking bench for the serial packet deframer: predicts every packet word
// from the received bytes and compares it against the block's output channel
// depends on spd_pkg, spd_if and the serial_packet_deframer_unit design
`timescale 1ns / 100ps

module testbench;
  import spd_pkg::*;

  // one packet word as the block reports it
  typedef struct packed {
    logic [7:0] data;
    spd_kind_e  kind;
    logic       eop;
    logic       cs_ok;
    logic       seq_ok;
    logic       resp;
    logic [7:0] tag;
  } deframe_word_t;

  // tracks the deframer state and the packet words still owed by the block
  class frame_checker;
    logic [7:0]    route_a, route_b, route_c;
    spd_phase_e    phase;
    logic [7:0]    left, sum, cur_tag, last_good;
    logic          excuse, route;
    deframe_word_t words_due[$];
    int unsigned   failures;

    function new();
      route_a   = '0;
      route_b   = '0;
      route_c   = '0;
      phase     = PH_HUNT1;
      left      = '0;
      sum       = '0;
      cur_tag   = '0;
      last_good = '0;
      excuse    = 1'b1;
      route     = 1'b0;
      failures  = 0;
    endfunction

    function void set_route(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_ROUTE_A: route_a = val;
        CFG_ROUTE_B: route_b = val;
        CFG_ROUTE_C: route_c = val;
        default: ;
      endcase
    endfunction

    function void owe_word(logic [7:0] b, spd_kind_e k, logic eop, logic csok, logic seqok,
                           logic resp);
      deframe_word_t w;
      w.data   = b;
      w.kind   = k;
      w.eop    = eop;
      w.cs_ok  = csok;
      w.seq_ok = seqok;
      w.resp   = resp;
      w.tag    = cur_tag;
      words_due.push_back(w);
    endfunction

    // advance the deframer by one received byte
    function void take_byte(logic [7:0] b);
      logic [7:0] next_good;
      logic       follows, csok;
      next_good = last_good + 8'd1;
      case (phase)
        PH_HUNT2: phase = (b == SYNC_SECOND) ? PH_TAG : PH_HUNT1;
        PH_TAG: begin
          cur_tag = b;
          phase   = PH_LEN;
        end
        PH_LEN: begin
          left  = b;
          sum   = b;
          route = 1'b0;
          phase = PH_CMD;
          owe_word(b, KIND_LEN, 1'b0, 1'b0, 1'b0, 1'b0);
        end
        PH_CMD: begin
          sum   = sum + b;
          route = (b == route_a) || (b == route_b) || (b == route_c);
          phase = (left == 8'd0) ? PH_CSUM : PH_DATA;
          owe_word(b, KIND_CMD, 1'b0, 1'b0, 1'b0, route);
        end
        PH_DATA: begin
          sum  = sum + b;
          left = left - 8'd1;
          if (left == 8'd0) phase = PH_CSUM;
          owe_word(b, KIND_DATA, 1'b0, 1'b0, 1'b0, route);
        end
        PH_CSUM: begin
          csok    = (sum == b);
          follows = (next_good == cur_tag);
          owe_word(b, KIND_CSUM, 1'b1, csok, follows || excuse, route);
          // only a good packet moves the sequence state
          if (csok) begin
            if (!follows) excuse = 1'b0;
            last_good = cur_tag;
          end
          phase = PH_HUNT1;
          left  = '0;
          sum   = '0;
        end
        default: phase = (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      endcase
    endfunction

    function void report(string what, deframe_word_t want, deframe_word_t got);
      failures++;
      if (failures <= 10) begin
        $display("%0t %s: expected byte %h kind %0d eop %b cs %b seq %b resp %b tag %h",
                 $realtime, what, want.data, want.kind, want.eop, want.cs_ok, want.seq_ok,
                 want.resp, want.tag);
        $display("%0t %s:      got byte %h kind %0d eop %b cs %b seq %b resp %b tag %h",
                 $realtime, what, got.data, got.kind, got.eop, got.cs_ok, got.seq_ok,
                 got.resp, got.tag);
      end
    endfunction

    // compare one delivered word with the oldest owed word
    function void match_word(deframe_word_t got);
      deframe_word_t want;
      if (words_due.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        want = words_due.pop_front();
        if (got !== want) report("word mismatch", want, got);
      end
    endfunction

    function void flag_leftover();
      if (words_due.size() != 0) begin
        failures += words_due.size();
        $display("%0d packet words never delivered", words_due.size());
      end
    endfunction

    function int unsigned pending();
      return words_due.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_data;

  spd_in_if  rx_if();
  spd_out_if res_if();

  frame_checker sb = new();

  bit          no_idle;
  bit          long_hold_req;
  int unsigned rcv_gap;
  int unsigned frame_bytes;
  logic [7:0]  next_tag;

  serial_packet_deframer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20ms;
    $display("serial_packet_deframer_unit: mismatch");
    $finish;
  end

  // idle lengths: mostly short, now and then long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // monitor both channels at the clock edge
  always @(posedge clk_i) begin : watch
    deframe_word_t seen;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen.data   = res_if.out_byte;
        seen.kind   = spd_kind_e'(res_if.byte_kind);
        seen.eop    = res_if.end_of_packet;
        seen.cs_ok  = res_if.checksum_ok;
        seen.seq_ok = res_if.sequence_ok;
        seen.resp   = res_if.to_response;
        seen.tag    = res_if.packet_tag;
        sb.match_word(seen);
      end
      if (rx_if.valid && rx_if.ready) sb.take_byte(rx_if.rx_byte);
    end
  end

  // output side: random stalls plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_count;
    res_if.ready <= 1'b0;
    rcv_gap = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        res_if.ready <= 1'b0;
        hold_count = 0;
        while (hold_count < 300) begin
          @(posedge clk_i);
          hold_count++;
        end
        long_hold_req = 1'b0;
      end else if (rcv_gap != 0) begin
        res_if.ready <= 1'b0;
        rcv_gap--;
      end else begin
        res_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) rcv_gap = pick_gap();
      end
    end
  end

  // send one received byte, with an optional idle gap in front
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
  endtask

  // one complete packet; data bytes random, checksum good or spoiled
  task automatic send_frame(input logic [7:0] tag, input logic [7:0] len,
                            input logic [7:0] cmd, input bit bad_csum);
    logic [7:0] csum;
    logic [7:0] d;
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(tag);
    push_byte(len);
    push_byte(cmd);
    csum = len + cmd;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      csum = csum + d;
      push_byte(d);
    end
    if (bad_csum) csum = csum ^ 8'($urandom_range(1, 255));
    push_byte(csum);
    frame_bytes += 6 + len;
    next_tag = tag + 8'd1;
  endtask

  // let the block empty out before touching the registers
  // the first edge lets the monitor record the last accepted byte
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_route(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_route(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_routes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    write_route(CFG_ROUTE_A, a);
    write_route(CFG_ROUTE_B, b);
    write_route(CFG_ROUTE_C, c);
  endtask

  // random traffic: mostly well-formed packets, some noise and broken syncs
  task automatic random_traffic(input int unsigned quota);
    int unsigned stop_at, r;
    logic [7:0]  tag, len, cmd;
    stop_at = frame_bytes + quota;
    while (frame_bytes < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        tag = ($urandom_range(0, 9) < 7) ? next_tag : 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 2)       len = 8'd255;
        else if (r < 12) len = 8'd0;
        else if (r < 20) len = 8'($urandom_range(11, 40));
        else             len = 8'($urandom_range(1, 10));
        case ($urandom_range(0, 5))
          0: cmd = sb.route_a;
          1: cmd = sb.route_b;
          2: cmd = sb.route_c;
          default: cmd = 8'($urandom);
        endcase
        send_frame(tag, len, cmd, $urandom_range(0, 6) == 0);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4))
          push_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
      end else begin
        // sync start with a wrong second byte, sometimes a cut-off header
        push_byte(SYNC_FIRST);
        if ($urandom_range(0, 1) == 0) begin
          push_byte(SYNC_SECOND ^ 8'($urandom_range(1, 255)));
        end else begin
          push_byte(SYNC_SECOND);
          push_byte(8'($urandom));
        end
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_ROUTE_A;
    cfg_data      <= 8'h00;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    frame_bytes   = 0;
    next_tag      = 8'h01;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_routes(8'hFF, 8'h00, 8'h5A);

    // directed: wrong second sync bytes (one of them a first sync byte), stray byte
    push_byte(SYNC_FIRST);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(SYNC_FIRST);
    push_byte(8'h00);
    // empty packet, top tag: out of sequence but excused, all-ones tag, command and checksum
    send_frame(8'hFF, 8'h00, 8'hFF, 1'b0);
    // tag wraps to zero, one data byte, spoiled checksum
    send_frame(8'h00, 8'h01, 8'h00, 1'b1);
    // out of sequence once the excuse is used, unrouted command
    send_frame(8'h05, 8'h00, 8'h13, 1'b0);

    random_traffic(425);
    wait_drained();

    set_routes(8'hFF, 8'hFF, 8'hFF);
    no_idle = 1'b1;
    random_traffic(425);
    wait_drained();

    no_idle = 1'b0;
    set_routes(8'($urandom), 8'($urandom), 8'($urandom));
    // long output hold-off while input keeps being offered
    long_hold_req = 1'b1;
    random_traffic(425);
    wait_drained();

    set_routes(8'h00, 8'h00, 8'h00);
    random_traffic(425);
    wait_drained();

    repeat (8) @(posedge clk_i);
    sb.flag_leftover();
    if (sb.failures == 0) begin
      $display("serial_packet_deframer_unit: match");
    end else begin
      $display("serial_packet_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule
